// ----- src/srh_pkg.sv -----
package srh_pkg;

    // Defaults for the top-level parameters.
    localparam int BINS_DEF      = 256;
    localparam int ACC_WIDTH_DEF = 48;
    localparam int AMP_WIDTH_DEF = 16;

    // Fixed widths of the ports.
    localparam int SUMS       = 8;
    localparam int ENERGY_W   = 32;
    localparam int AMP_PORT_W = 16;
    localparam int OUT_W      = 48;
    localparam int BIN_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register values after reset.
    localparam logic [31:0]        LOWER_RST = 32'd0;
    localparam logic [31:0]        UPPER_RST = 32'd65536;
    localparam logic [COUNT_W-1:0] COUNT_RST = 9'd256;
    localparam logic [31:0]        SCALE_RST = 32'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1,
        REG_COUNT = 2'd2,
        REG_SCALE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_ACC  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_UPD
    } state_t;

    // Step enables from the sequencer to the datapath.
    typedef struct packed {
        logic clearing;
        logic accept;
        logic mul_en;
        logic addr_en;
        logic upd_en;
    } ctrl_t;

    // What the update step must do with the row it reads.
    typedef struct packed {
        logic             write;
        logic             in_range;
        logic             zero;
        logic [BIN_W-1:0] bin;
    } meta_t;

endpackage

// ----- src/srh_ctrl.sv -----
module srh_ctrl #(
    parameter int BINS = srh_pkg::BINS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output srh_pkg::ctrl_t        ctrl,
    output logic [$clog2(BINS)-1:0] clr_addr
);

    localparam int ADDR_W = $clog2(BINS);

    srh_pkg::state_t   state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              clr_last;

    assign clr_last = (clr_reg == ADDR_W'(BINS - 1));
    assign clr_addr = clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srh_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            srh_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = srh_pkg::ST_IDLE;
                    clr_next   = '0;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            srh_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = srh_pkg::ST_MUL;
                end
            end
            srh_pkg::ST_MUL:  state_next = srh_pkg::ST_ADDR;
            srh_pkg::ST_ADDR: state_next = srh_pkg::ST_UPD;
            srh_pkg::ST_UPD:  state_next = srh_pkg::ST_IDLE;
            default:          state_next = srh_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        case (state_reg)
            srh_pkg::ST_CLEAR: ctrl.clearing = 1'b1;
            srh_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                ctrl.accept = start;
            end
            srh_pkg::ST_MUL:  ctrl.mul_en  = 1'b1;
            srh_pkg::ST_ADDR: ctrl.addr_en = 1'b1;
            srh_pkg::ST_UPD:  ctrl.upd_en  = 1'b1;
            default:          ctrl         = '0;
        endcase
    end

endmodule

// ----- src/srh_bin_mem.sv -----
module srh_bin_mem #(
    parameter int BINS      = srh_pkg::BINS_DEF,
    parameter int ACC_WIDTH = srh_pkg::ACC_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [$clog2(BINS)-1:0]                   waddr,
    input  logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0]   wdata,
    input  logic                                      re,
    input  logic [$clog2(BINS)-1:0]                   raddr,
    output logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0]   rdata
);

    // One row holds the eight sums of a bin.
    logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0] mem [BINS];
    logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/srh_front.sv -----
module srh_front #(
    parameter int BINS      = srh_pkg::BINS_DEF,
    parameter int AMP_WIDTH = srh_pkg::AMP_WIDTH_DEF
) (
    input  logic                                       clk,
    input  srh_pkg::ctrl_t                             ctrl,
    input  logic                                       opcode,
    input  logic signed [srh_pkg::ENERGY_W-1:0]        energy,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]      up_re,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]      up_im,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]      down_re,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]      down_im,
    input  logic [srh_pkg::BIN_W-1:0]                  read_bin,
    input  logic signed [srh_pkg::ENERGY_W-1:0]        lower_limit,
    input  logic signed [srh_pkg::ENERGY_W-1:0]        upper_limit,
    input  logic [srh_pkg::COUNT_W-1:0]                bin_count,
    input  logic [31:0]                                bin_scale,
    output logic [$clog2(BINS)-1:0]                    raddr,
    output logic [$clog2(BINS)-1:0]                    waddr,
    output logic [srh_pkg::SUMS-1:0][2*AMP_WIDTH:0]    vals,
    output srh_pkg::meta_t                             meta
);

    localparam int ADDR_W = $clog2(BINS);
    localparam int PROD_W = 2 * AMP_WIDTH;
    localparam int VAL_W  = PROD_W + 1;
    localparam int EXT_W  = (AMP_WIDTH > srh_pkg::AMP_PORT_W) ? AMP_WIDTH : srh_pkg::AMP_PORT_W;
    localparam int CNT_W  = (ADDR_W + 1 > srh_pkg::COUNT_W) ? ADDR_W + 1 : srh_pkg::COUNT_W;

    // Amplitude slots and product slots.
    localparam int A_UR = 0;
    localparam int A_UI = 1;
    localparam int A_DR = 2;
    localparam int A_DI = 3;
    localparam int P_URUR = 0;
    localparam int P_UIUI = 1;
    localparam int P_DRDR = 2;
    localparam int P_DIDI = 3;
    localparam int P_URDR = 4;
    localparam int P_UIDI = 5;
    localparam int P_URDI = 6;
    localparam int P_UIDR = 7;

    // The low AMP_WIDTH bits of the port value, sign-extended from bit AMP_WIDTH-1.
    function automatic logic signed [AMP_WIDTH-1:0] amp_ext(input logic [srh_pkg::AMP_PORT_W-1:0] x);
        logic [EXT_W-1:0] z;
        z = EXT_W'(x);
        return signed'(z[AMP_WIDTH-1:0]);
    endfunction

    srh_pkg::op_t                 op_reg;
    logic [31:0]                  diff_reg;
    logic                         inr_reg;
    logic [srh_pkg::BIN_W-1:0]    rbin_reg;
    logic signed [AMP_WIDTH-1:0]  amp_reg [4];
    logic [63:0]                  scaled_reg;
    logic signed [PROD_W-1:0]     prod_reg [8];
    logic [ADDR_W-1:0]            addr_reg;
    logic [srh_pkg::SUMS-1:0][VAL_W-1:0] vals_reg;
    srh_pkg::meta_t               meta_reg;

    logic [CNT_W-1:0]             cnt;
    logic [31:0]                  raw_bin;
    logic [ADDR_W-1:0]            acc_bin;
    logic                         rbin_ok;
    logic [srh_pkg::SUMS-1:0][VAL_W-1:0] vals_calc;

    // Capture the request; the energy offset from the lower limit is below 2^32 when in range.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            op_reg        <= srh_pkg::op_t'(opcode);
            diff_reg      <= energy - lower_limit;
            inr_reg       <= (energy > lower_limit) && (energy < upper_limit);
            rbin_reg      <= read_bin;
            amp_reg[A_UR] <= amp_ext(up_re);
            amp_reg[A_UI] <= amp_ext(up_im);
            amp_reg[A_DR] <= amp_ext(down_re);
            amp_reg[A_DI] <= amp_ext(down_im);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            scaled_reg       <= diff_reg * bin_scale;
            prod_reg[P_URUR] <= amp_reg[A_UR] * amp_reg[A_UR];
            prod_reg[P_UIUI] <= amp_reg[A_UI] * amp_reg[A_UI];
            prod_reg[P_DRDR] <= amp_reg[A_DR] * amp_reg[A_DR];
            prod_reg[P_DIDI] <= amp_reg[A_DI] * amp_reg[A_DI];
            prod_reg[P_URDR] <= amp_reg[A_UR] * amp_reg[A_DR];
            prod_reg[P_UIDI] <= amp_reg[A_UI] * amp_reg[A_DI];
            prod_reg[P_URDI] <= amp_reg[A_UR] * amp_reg[A_DI];
            prod_reg[P_UIDR] <= amp_reg[A_UI] * amp_reg[A_DR];
        end
    end

    // Bin index: integer part of the Q32.32 product, clamped to the bins in use.
    always_comb
    begin
        if (bin_count == '0)
        begin
            cnt = CNT_W'(1);
        end
        else if (CNT_W'(bin_count) > CNT_W'(BINS))
        begin
            cnt = CNT_W'(BINS);
        end
        else
        begin
            cnt = CNT_W'(bin_count);
        end
        raw_bin = scaled_reg[63:32];
        if (raw_bin >= 32'(cnt))
        begin
            acc_bin = ADDR_W'(cnt - CNT_W'(1));
        end
        else
        begin
            acc_bin = ADDR_W'(raw_bin);
        end
        rbin_ok = (CNT_W'(rbin_reg) < CNT_W'(BINS));
        raddr   = (op_reg == srh_pkg::OP_READ) ? ADDR_W'(rbin_reg) : acc_bin;
    end

    // conj(a)*b terms; conj(u)*u and conj(d)*d are real.
    always_comb
    begin
        vals_calc    = '0;
        vals_calc[0] = VAL_W'(prod_reg[P_URUR]) + VAL_W'(prod_reg[P_UIUI]);
        vals_calc[2] = VAL_W'(prod_reg[P_URDR]) + VAL_W'(prod_reg[P_UIDI]);
        vals_calc[3] = VAL_W'(prod_reg[P_URDI]) - VAL_W'(prod_reg[P_UIDR]);
        vals_calc[4] = VAL_W'(prod_reg[P_URDR]) + VAL_W'(prod_reg[P_UIDI]);
        vals_calc[5] = VAL_W'(prod_reg[P_UIDR]) - VAL_W'(prod_reg[P_URDI]);
        vals_calc[6] = VAL_W'(prod_reg[P_DRDR]) + VAL_W'(prod_reg[P_DIDI]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.addr_en)
        begin
            addr_reg <= raddr;
            if (op_reg == srh_pkg::OP_READ)
            begin
                vals_reg          <= '0;
                meta_reg.write    <= 1'b0;
                meta_reg.in_range <= 1'b0;
                meta_reg.zero     <= !rbin_ok;
                meta_reg.bin      <= rbin_reg;
            end
            else
            begin
                vals_reg          <= vals_calc;
                meta_reg.write    <= inr_reg;
                meta_reg.in_range <= inr_reg;
                meta_reg.zero     <= !inr_reg;
                meta_reg.bin      <= inr_reg ? srh_pkg::BIN_W'(acc_bin) : '0;
            end
        end
    end

    assign waddr = addr_reg;
    assign vals  = vals_reg;
    assign meta  = meta_reg;

endmodule

// ----- src/srh_accum.sv -----
module srh_accum #(
    parameter int ACC_WIDTH = srh_pkg::ACC_WIDTH_DEF,
    parameter int AMP_WIDTH = srh_pkg::AMP_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          upd_en,
    input  srh_pkg::meta_t                                meta,
    input  logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0]       rdata,
    input  logic [srh_pkg::SUMS-1:0][2*AMP_WIDTH:0]       vals,
    output logic                                          wr_en,
    output logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0]       wr_data,
    output logic                                          done,
    output logic                                          in_range,
    output logic [srh_pkg::BIN_W-1:0]                     bin,
    output logic [srh_pkg::SUMS-1:0][srh_pkg::OUT_W-1:0]  sums
);

    localparam int VAL_W = 2 * AMP_WIDTH + 1;
    localparam int SUM_W = ((ACC_WIDTH > VAL_W) ? ACC_WIDTH : VAL_W) + 1;
    localparam logic signed [SUM_W-1:0] ACC_MAX =
        {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [SUM_W-1:0] sum [srh_pkg::SUMS];
    logic                    done_reg;
    logic                    in_range_reg;
    logic [srh_pkg::BIN_W-1:0] bin_reg;
    logic [srh_pkg::SUMS-1:0][srh_pkg::OUT_W-1:0] sums_reg;

    // Eight independent saturating adders.
    always_comb
    begin
        for (int k = 0; k < srh_pkg::SUMS; k++)
        begin
            sum[k] = SUM_W'(signed'(rdata[k])) + SUM_W'(signed'(vals[k]));
            if (sum[k] > ACC_MAX)
            begin
                wr_data[k] = ACC_MAX[ACC_WIDTH-1:0];
            end
            else if (sum[k] < ACC_MIN)
            begin
                wr_data[k] = ACC_MIN[ACC_WIDTH-1:0];
            end
            else
            begin
                wr_data[k] = sum[k][ACC_WIDTH-1:0];
            end
        end
    end

    assign wr_en = upd_en && meta.write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= upd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            in_range_reg <= meta.in_range;
            bin_reg      <= meta.bin;
            for (int k = 0; k < srh_pkg::SUMS; k++)
            begin
                sums_reg[k] <= meta.zero ? '0 : srh_pkg::OUT_W'(signed'(wr_data[k]));
            end
        end
    end

    assign done     = done_reg;
    assign in_range = in_range_reg;
    assign bin      = bin_reg;
    assign sums     = sums_reg;

endmodule

// ----- src/spin_resolved_energy_histogram.sv -----
// Spin-resolved energy histogram.
//
// Requests enter on the command channel: a request is taken at a rising edge where start
// is high and busy is low. With opcode accumulate, an energy strictly between the two limits
// picks a bin and the four spin-pair products are added into that bin with saturation; with
// opcode read, the eight sums of read_bin are returned (zeros if read_bin is not below BINS).
// Every request gives one result, shown for exactly one cycle with done high; the receiver
// cannot hold it off, so none is ever held. The result appears once the request has passed
// its steps, and the next request can be taken in that same cycle; none is taken while one
// is in flight, due to the read-modify-write of a bin row through the sum memory with one
// read and one write port: scale and multiply, memory read, saturating add with write-back.
// Configuration registers are written over their own valid/ready channel at any time; cfg_ready
// is always high. They should only change while the block is idle.
// After reset the sum memory is cleared one row a cycle, from row 0 to row BINS-1; busy stays
// high during that pass and configuration writes are still taken.
module spin_resolved_energy_histogram #(
    parameter int BINS      = srh_pkg::BINS_DEF,
    parameter int ACC_WIDTH = srh_pkg::ACC_WIDTH_DEF,
    parameter int AMP_WIDTH = srh_pkg::AMP_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Command channel.
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    opcode,
    input  logic signed [srh_pkg::ENERGY_W-1:0]     energy,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]   up_re,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]   up_im,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]   down_re,
    input  logic signed [srh_pkg::AMP_PORT_W-1:0]   down_im,
    input  logic [srh_pkg::BIN_W-1:0]               read_bin,
    // Result strobe and payload.
    output logic                                    done,
    output logic                                    in_range,
    output logic [srh_pkg::BIN_W-1:0]               bin,
    output logic signed [srh_pkg::OUT_W-1:0]        upup_re,
    output logic signed [srh_pkg::OUT_W-1:0]        upup_im,
    output logic signed [srh_pkg::OUT_W-1:0]        updown_re,
    output logic signed [srh_pkg::OUT_W-1:0]        updown_im,
    output logic signed [srh_pkg::OUT_W-1:0]        downup_re,
    output logic signed [srh_pkg::OUT_W-1:0]        downup_im,
    output logic signed [srh_pkg::OUT_W-1:0]        downdown_re,
    output logic signed [srh_pkg::OUT_W-1:0]        downdown_im,
    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [srh_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [srh_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int ADDR_W = $clog2(BINS);
    localparam int VAL_W  = 2 * AMP_WIDTH + 1;

    // Configuration registers.
    logic signed [srh_pkg::ENERGY_W-1:0] lower_reg;
    logic signed [srh_pkg::ENERGY_W-1:0] upper_reg;
    logic [srh_pkg::COUNT_W-1:0]         count_reg;
    logic [31:0]                         scale_reg;

    srh_pkg::ctrl_t                          ctrl;
    logic [ADDR_W-1:0]                       clr_addr;
    logic [ADDR_W-1:0]                       raddr;
    logic [ADDR_W-1:0]                       upd_addr;
    logic [srh_pkg::SUMS-1:0][VAL_W-1:0]     vals;
    srh_pkg::meta_t                          meta;
    logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0] rdata;
    logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0] upd_data;
    logic                                    upd_wr;
    logic                                    mem_we;
    logic [ADDR_W-1:0]                       mem_waddr;
    logic [srh_pkg::SUMS-1:0][ACC_WIDTH-1:0] mem_wdata;
    logic [srh_pkg::SUMS-1:0][srh_pkg::OUT_W-1:0] sums;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= srh_pkg::LOWER_RST;
            upper_reg <= srh_pkg::UPPER_RST;
            count_reg <= srh_pkg::COUNT_RST;
            scale_reg <= srh_pkg::SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (srh_pkg::cfg_reg_t'(cfg_index))
                srh_pkg::REG_LOWER: lower_reg <= cfg_data;
                srh_pkg::REG_UPPER: upper_reg <= cfg_data;
                srh_pkg::REG_COUNT: count_reg <= cfg_data[srh_pkg::COUNT_W-1:0];
                srh_pkg::REG_SCALE: scale_reg <= cfg_data;
                default:            scale_reg <= scale_reg;
            endcase
        end
    end

    // Sequencer: clearing pass, then one request at a time through four steps.
    srh_ctrl #(
        .BINS(BINS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .ctrl     (ctrl),
        .clr_addr (clr_addr)
    );

    // Bin selection and the spin-pair products.
    srh_front #(
        .BINS      (BINS),
        .AMP_WIDTH (AMP_WIDTH)
    ) u_front (
        .clk         (clk),
        .ctrl        (ctrl),
        .opcode      (opcode),
        .energy      (energy),
        .up_re       (up_re),
        .up_im       (up_im),
        .down_re     (down_re),
        .down_im     (down_im),
        .read_bin    (read_bin),
        .lower_limit (lower_reg),
        .upper_limit (upper_reg),
        .bin_count   (count_reg),
        .bin_scale   (scale_reg),
        .raddr       (raddr),
        .waddr       (upd_addr),
        .vals        (vals),
        .meta        (meta)
    );

    // The sum memory. The row read for a request is written back in the next cycle, and the
    // next request cannot reach its own read before that write, so no forwarding is needed.
    assign mem_we    = ctrl.clearing || upd_wr;
    assign mem_waddr = ctrl.clearing ? clr_addr : upd_addr;
    assign mem_wdata = ctrl.clearing ? '0 : upd_data;

    srh_bin_mem #(
        .BINS      (BINS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (ctrl.addr_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Saturating update, write-back and the result register.
    srh_accum #(
        .ACC_WIDTH (ACC_WIDTH),
        .AMP_WIDTH (AMP_WIDTH)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (ctrl.upd_en),
        .meta     (meta),
        .rdata    (rdata),
        .vals     (vals),
        .wr_en    (upd_wr),
        .wr_data  (upd_data),
        .done     (done),
        .in_range (in_range),
        .bin      (bin),
        .sums     (sums)
    );

    assign upup_re     = sums[0];
    assign upup_im     = sums[1];
    assign updown_re   = sums[2];
    assign updown_im   = sums[3];
    assign downup_re   = sums[4];
    assign downup_im   = sums[5];
    assign downdown_re = sums[6];
    assign downdown_im = sums[7];

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy in the next cycle");

    a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.upd_en |=> done)
        else $error("update step gave no result strobe");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctrl.upd_en))
        else $error("result strobe without an update step");

    a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
        upd_wr |-> (!ctrl.clearing && $past(ctrl.addr_en)))
        else $error("write-back not preceded by its row read");
`endif

endmodule
